// ===== design/assert_macros.svh =====
// assertion macros shared by the cache simulator modules
// no dependencies; included by the files that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define SAC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define SAC_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define SAC_ASSERT(label, clk, rst, prop, msg)

`define SAC_ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

// ===== design/sac_pkg.sv =====
// types, codes and constants of the set associative cache simulator
// no dependencies; used by sac_ctrl, sac_datapath and the top module
package sac_pkg;

   localparam int ADDR_W = 64;
   localparam int TAG_W = 64;
   localparam int AGE_W = 3;
   localparam logic [AGE_W-1:0] AGE_MAX = 3'd7;
   localparam int CNT_OUT_W = 32;

   localparam int DEF_MAX_SET_BITS = 8;
   localparam int DEF_MAX_WAYS = 8;
   localparam int DEF_COUNT_BITS = 32;

   localparam int SET_BITS_W = 4;
   localparam int WAYS_W = 4;
   localparam int BLOCK_BITS_W = 6;

   localparam logic [SET_BITS_W-1:0] SET_BITS_RESET = 4'd4;
   localparam logic [WAYS_W-1:0] WAYS_RESET = 4'd1;
   localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RESET = 6'd4;

   localparam int PADDR_W = 4;
   localparam int PDATA_W = 32;

   typedef enum logic [1:0] {
      CSR_SET_BITS = 2'd0,
      CSR_WAYS = 2'd1,
      CSR_BLOCK_BITS = 2'd2,
      CSR_SPARE = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_FETCH = 2'd0,
      MODE_LOAD = 2'd1,
      MODE_STORE = 2'd2,
      MODE_MODIFY = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      OUTCOME_HIT = 2'd0,
      OUTCOME_FILL = 2'd1,
      OUTCOME_EVICT = 2'd2,
      OUTCOME_NONE = 2'd3
   } outcome_type;

   typedef struct packed {
      logic [SET_BITS_W-1:0] set_bits;
      logic [WAYS_W-1:0] ways;
      logic [BLOCK_BITS_W-1:0] block_bits;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic lookup;
      logic update;
      logic last;
      logic second;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

// ===== design/sac_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies; holds the cache rows of the simulator
module sac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/sac_ctrl.sv =====
// controller state machine of the cache simulator: sequences lookup and update
// depends on sac_pkg and assert_macros.svh
`include "assert_macros.svh"

module sac_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [1:0]          req_mode,
   output logic                req_stall,
   input  sac_pkg::status_type status,
   output sac_pkg::cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE,
      ST_SECOND
   } state_type;

   state_type state_ff, state_in;
   logic modify_ff, modify_in;

   always_comb begin
      state_in = state_ff;
      modify_in = modify_ff;
      cmd = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.capture = req_valid;
            if (req_valid && (req_mode != sac_pkg::MODE_FETCH)) begin
               state_in = ST_LOOKUP;
               modify_in = (req_mode == sac_pkg::MODE_MODIFY);
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (status.out_free) begin
               cmd.update = 1'b1;
               cmd.last = !modify_ff;
               state_in = modify_ff ? ST_SECOND : ST_IDLE;
            end
         end
         ST_SECOND: begin
            if (status.out_free) begin
               cmd.second = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         modify_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         modify_ff <= modify_in;
      end
   end

   `SAC_ASSERT(a_lookup_then_update, clock, reset, state_ff == ST_LOOKUP |=> state_ff == ST_UPDATE, "lookup not followed by update")
   `SAC_ASSERT(a_second_only_modify, clock, reset, state_ff == ST_SECOND |-> modify_ff, "second word without modify")
   `SAC_ASSERT(a_emit_when_free, clock, reset, (cmd.update || cmd.second) |-> status.out_free, "word emitted into a full output")

endmodule

// ===== design/sac_datapath.sv =====
// datapath of the cache simulator: address split, row ram, lru update, counters
// depends on sac_pkg, sac_ram and assert_macros.svh
`include "assert_macros.svh"

module sac_datapath #(
   parameter int MAX_SET_BITS = sac_pkg::DEF_MAX_SET_BITS,
   parameter int MAX_WAYS = sac_pkg::DEF_MAX_WAYS,
   parameter int COUNT_BITS = sac_pkg::DEF_COUNT_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  sac_pkg::cfg_type            cfg,
   input  sac_pkg::cmd_type            cmd,
   output sac_pkg::status_type         status,
   input  logic [sac_pkg::ADDR_W-1:0]  req_address,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_outcome,
   output logic                        rsp_last,
   output logic [sac_pkg::CNT_OUT_W-1:0] rsp_hit_count,
   output logic [sac_pkg::CNT_OUT_W-1:0] rsp_miss_count,
   output logic [sac_pkg::CNT_OUT_W-1:0] rsp_evict_count
);

   localparam int ADDR_W = sac_pkg::ADDR_W;
   localparam int TAG_W = sac_pkg::TAG_W;
   localparam int AGE_W = sac_pkg::AGE_W;
   localparam int CNT_OUT_W = sac_pkg::CNT_OUT_W;
   localparam int SET_W = MAX_SET_BITS;
   localparam int NUM_SETS = 1 << MAX_SET_BITS;
   localparam int SB_W = $clog2(MAX_SET_BITS + 1);
   localparam int NW_W = $clog2(MAX_WAYS + 1);
   localparam int AGE_LO = MAX_WAYS * TAG_W;
   localparam int VLD_LO = MAX_WAYS * (TAG_W + AGE_W);
   localparam int ROW_W = MAX_WAYS * (1 + AGE_W + TAG_W);

   logic [ADDR_W-1:0] addr_ff;
   logic [TAG_W-1:0] tag_ff;
   logic [SET_W-1:0] set_ff;
   logic row_ok_ff;
   logic [NUM_SETS-1:0] row_vld_ff;
   logic [COUNT_BITS-1:0] hit_cnt_ff, hit_cnt_in;
   logic [COUNT_BITS-1:0] miss_cnt_ff, miss_cnt_in;
   logic [COUNT_BITS-1:0] evict_cnt_ff, evict_cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   sac_pkg::outcome_type rsp_outcome_ff;
   logic rsp_last_ff;
   logic [CNT_OUT_W-1:0] rsp_hit_ff, rsp_miss_ff, rsp_evict_ff;

   logic [SB_W-1:0] sb_eff;
   logic [NW_W-1:0] nw_eff;
   logic [ADDR_W-1:0] shifted;
   logic [SET_W-1:0] set_lu;
   logic [TAG_W-1:0] tag_lu;

   logic [ROW_W-1:0] rd_row, wr_row;
   logic [MAX_WAYS-1:0] way_use, cur_valid, new_valid;
   logic [MAX_WAYS-1:0][AGE_W-1:0] cur_age, new_age;
   logic [MAX_WAYS-1:0][TAG_W-1:0] cur_tag, new_tag;
   logic [MAX_WAYS-1:0] hit_vec, hit_sel, free_vec, free_sel, vic_sel;
   logic [AGE_W-1:0] hit_age, vic_age;
   sac_pkg::outcome_type outcome;
   logic emit;

   // address split
   always_comb begin
      sb_eff = (int'(cfg.set_bits) > MAX_SET_BITS) ? SB_W'(MAX_SET_BITS)
                                                    : SB_W'(cfg.set_bits);
      if (cfg.ways == '0) begin
         nw_eff = NW_W'(1);
      end else if (int'(cfg.ways) > MAX_WAYS) begin
         nw_eff = NW_W'(MAX_WAYS);
      end else begin
         nw_eff = NW_W'(cfg.ways);
      end
      shifted = addr_ff >> cfg.block_bits;
      set_lu = shifted[SET_W-1:0] & ~({SET_W{1'b1}} << sb_eff);
      tag_lu = shifted >> sb_eff;
   end

   sac_ram #(
      .WIDTH(ROW_W),
      .DEPTH(NUM_SETS)
   ) u_row_ram (
      .clock(clock),
      .wr_en(cmd.update),
      .wr_addr(set_ff),
      .wr_data(wr_row),
      .rd_en(cmd.lookup),
      .rd_addr(set_lu),
      .rd_data(rd_row)
   );

   // row unpack, hit search, victim choice and lru update
   always_comb begin
      logic [AGE_W-1:0] best;
      int vic;
      best = '0;
      vic = 0;
      hit_age = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         way_use[w] = (NW_W'(w) < nw_eff);
         cur_valid[w] = row_ok_ff & rd_row[VLD_LO + w];
         cur_age[w] = row_ok_ff ? rd_row[AGE_LO + w*AGE_W +: AGE_W] : '0;
         cur_tag[w] = rd_row[w*TAG_W +: TAG_W];
         hit_vec[w] = way_use[w] & cur_valid[w] & (cur_tag[w] == tag_ff);
         free_vec[w] = way_use[w] & ~cur_valid[w];
      end
      hit_sel = hit_vec & (~hit_vec + MAX_WAYS'(1));
      free_sel = free_vec & (~free_vec + MAX_WAYS'(1));
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (hit_sel[w]) begin
            hit_age = hit_age | cur_age[w];
         end
      end
      best = cur_age[0];
      for (int w = 1; w < MAX_WAYS; w++) begin
         if (way_use[w] && (cur_age[w] > best)) begin
            best = cur_age[w];
            vic = w;
         end
      end
      vic_age = best;
      vic_sel = '0;
      vic_sel[vic] = 1'b1;

      new_valid = cur_valid;
      new_age = cur_age;
      new_tag = cur_tag;
      if (|hit_vec) begin
         outcome = sac_pkg::OUTCOME_HIT;
         for (int w = 0; w < MAX_WAYS; w++) begin
            if (way_use[w] && cur_valid[w] && (cur_age[w] < hit_age)) begin
               new_age[w] = AGE_W'(cur_age[w] + 1'b1);
            end
            if (hit_sel[w]) begin
               new_age[w] = '0;
            end
         end
      end else if (|free_vec) begin
         outcome = sac_pkg::OUTCOME_FILL;
         for (int w = 0; w < MAX_WAYS; w++) begin
            if (way_use[w] && cur_valid[w] && (cur_age[w] < sac_pkg::AGE_MAX)) begin
               new_age[w] = AGE_W'(cur_age[w] + 1'b1);
            end
            if (free_sel[w]) begin
               new_valid[w] = 1'b1;
               new_tag[w] = tag_ff;
               new_age[w] = '0;
            end
         end
      end else begin
         outcome = sac_pkg::OUTCOME_EVICT;
         for (int w = 0; w < MAX_WAYS; w++) begin
            if (way_use[w] && (cur_age[w] < vic_age)) begin
               new_age[w] = AGE_W'(cur_age[w] + 1'b1);
            end
            if (vic_sel[w]) begin
               new_tag[w] = tag_ff;
               new_age[w] = '0;
            end
         end
      end
      wr_row = {new_valid, new_age, new_tag};
   end

   // saturating counters and output word
   always_comb begin
      hit_cnt_in = hit_cnt_ff;
      miss_cnt_in = miss_cnt_ff;
      evict_cnt_in = evict_cnt_ff;
      if (cmd.second || (cmd.update && (outcome == sac_pkg::OUTCOME_HIT))) begin
         if (hit_cnt_ff != '1) begin
            hit_cnt_in = hit_cnt_ff + 1'b1;
         end
      end
      if (cmd.update && (outcome != sac_pkg::OUTCOME_HIT)) begin
         if (miss_cnt_ff != '1) begin
            miss_cnt_in = miss_cnt_ff + 1'b1;
         end
      end
      if (cmd.update && (outcome == sac_pkg::OUTCOME_EVICT)) begin
         if (evict_cnt_ff != '1) begin
            evict_cnt_in = evict_cnt_ff + 1'b1;
         end
      end
      emit = cmd.update | cmd.second;
      rsp_valid_in = emit | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
         hit_cnt_ff <= '0;
         miss_cnt_ff <= '0;
         evict_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.update) begin
            row_vld_ff[set_ff] <= 1'b1;
         end
         hit_cnt_ff <= hit_cnt_in;
         miss_cnt_ff <= miss_cnt_in;
         evict_cnt_ff <= evict_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         addr_ff <= req_address;
      end
      if (cmd.lookup) begin
         tag_ff <= tag_lu;
         set_ff <= set_lu;
         row_ok_ff <= row_vld_ff[set_lu];
      end
      if (emit) begin
         rsp_outcome_ff <= cmd.second ? sac_pkg::OUTCOME_HIT : outcome;
         rsp_last_ff <= cmd.second | cmd.last;
         rsp_hit_ff <= CNT_OUT_W'(hit_cnt_in);
         rsp_miss_ff <= CNT_OUT_W'(miss_cnt_in);
         rsp_evict_ff <= CNT_OUT_W'(evict_cnt_in);
      end
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_outcome = rsp_outcome_ff;
   assign rsp_last = rsp_last_ff;
   assign rsp_hit_count = rsp_hit_ff;
   assign rsp_miss_count = rsp_miss_ff;
   assign rsp_evict_count = rsp_evict_ff;

   `SAC_ASSERT(a_hit_onehot, clock, reset, cmd.update |-> $onehot0(hit_sel), "more than one hit way selected")
   `SAC_ASSERT(a_evict_full_set, clock, reset, (cmd.update && outcome == sac_pkg::OUTCOME_EVICT) |-> ((cur_valid & way_use) == way_use), "eviction with a free line")
   `SAC_ASSERT_NEVER(a_evict_le_miss, clock, reset, evict_cnt_ff > miss_cnt_ff, "more evictions than misses")
   `SAC_ASSERT(a_hit_monotonic, clock, reset, !$past(reset) |-> hit_cnt_ff >= $past(hit_cnt_ff), "hit count went down")

endmodule

// ===== design/set_assoc_cache_lru_sim_top.sv =====
// Set associative cache simulator with true LRU replacement.
// Input channel req_*: one trace word per access, mode (fetch, load, store,
// modify) and a 64-bit byte address. A fetch word is taken and dropped.
// Result channel rsp_*: one word per load or store, two for a modify (the
// second always a hit, last set only on the final word), each with the
// outcome and the hit, miss and eviction totals after it.
// Configuration: APB-style port, set_bits at 0x0, ways at 0x4, block_bits at 0x8.
// Timing: an access is taken, the address is split and its set row read from
// the row ram in the next cycle, and the row is then compared, updated and
// written back once the output register is free, which also loads the result word.
// A new access is taken only once the last one is done, second word included for
// a modify; the row ram read then write-back of the same set bounds the rate.
// The output register lets one result wait while the next access is taken;
// a stalled receiver holds the block in its update or second-word step until the word leaves.
// Reset (synchronous) clears the counters and per-set row flags (lines then read
// invalid, age 0), restores set_bits 4, ways 1, block_bits 4; ready the cycle after.
// depends on sac_pkg, sac_ctrl, sac_datapath, sac_ram
module set_assoc_cache_lru_sim_top #(
   parameter int MAX_SET_BITS = sac_pkg::DEF_MAX_SET_BITS,
   parameter int MAX_WAYS = sac_pkg::DEF_MAX_WAYS,
   parameter int COUNT_BITS = sac_pkg::DEF_COUNT_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_mode,
   input  logic [sac_pkg::ADDR_W-1:0]     req_address,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_outcome,
   output logic                           rsp_last,
   output logic [sac_pkg::CNT_OUT_W-1:0]  rsp_hit_count,
   output logic [sac_pkg::CNT_OUT_W-1:0]  rsp_miss_count,
   output logic [sac_pkg::CNT_OUT_W-1:0]  rsp_evict_count,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [sac_pkg::PADDR_W-1:0]    paddr,
   input  logic [sac_pkg::PDATA_W-1:0]    pwdata,
   output logic [sac_pkg::PDATA_W-1:0]    prdata,
   output logic                           pready
);

   localparam int PDATA_W = sac_pkg::PDATA_W;

   sac_pkg::cfg_type cfg_ff, cfg_in;
   sac_pkg::csr_index_type csr_idx;
   sac_pkg::cmd_type cmd;
   sac_pkg::status_type status;

   assign csr_idx = sac_pkg::csr_index_type'(paddr[3:2]);
   assign pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite && pready) begin
         case (csr_idx)
            sac_pkg::CSR_SET_BITS: cfg_in.set_bits = pwdata[sac_pkg::SET_BITS_W-1:0];
            sac_pkg::CSR_WAYS: cfg_in.ways = pwdata[sac_pkg::WAYS_W-1:0];
            sac_pkg::CSR_BLOCK_BITS: cfg_in.block_bits = pwdata[sac_pkg::BLOCK_BITS_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         sac_pkg::CSR_SET_BITS: prdata = PDATA_W'(cfg_ff.set_bits);
         sac_pkg::CSR_WAYS: prdata = PDATA_W'(cfg_ff.ways);
         sac_pkg::CSR_BLOCK_BITS: prdata = PDATA_W'(cfg_ff.block_bits);
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.set_bits <= sac_pkg::SET_BITS_RESET;
         cfg_ff.ways <= sac_pkg::WAYS_RESET;
         cfg_ff.block_bits <= sac_pkg::BLOCK_BITS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sac_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_mode(req_mode),
      .req_stall(req_stall),
      .status(status),
      .cmd(cmd)
   );

   sac_datapath #(
      .MAX_SET_BITS(MAX_SET_BITS),
      .MAX_WAYS(MAX_WAYS),
      .COUNT_BITS(COUNT_BITS)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .cmd(cmd),
      .status(status),
      .req_address(req_address),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_outcome(rsp_outcome),
      .rsp_last(rsp_last),
      .rsp_hit_count(rsp_hit_count),
      .rsp_miss_count(rsp_miss_count),
      .rsp_evict_count(rsp_evict_count)
   );

endmodule
